>>> src/wvsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsd_pkg
// Shared widths, register codes, ladder words and stage payload types of the
// wind vane sector decoder.
// ----------------------------------------------------------------------------
package wvsd_pkg;

    localparam int SECTOR_COUNT = 16;
    localparam int SECTOR_W     = 4;
    localparam int SAMPLE_W     = 10;
    localparam int CFG_W        = 10;
    localparam int SUM_W        = 13;
    localparam int CNT_W        = 3;
    localparam int DEG_W        = 9;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STUCK_LOW  = 3'd0,
        REG_STUCK_HIGH = 3'd1,
        REG_SPAN_MIN   = 3'd2,
        REG_SPAN_MAX   = 3'd3,
        REG_HYSTERESIS = 3'd4
    } wvsd_reg_t;

    localparam logic [SAMPLE_W-1:0] LADDER [SECTOR_COUNT] = '{
        10'd238, 10'd617, 10'd562, 10'd940, 10'd930, 10'd957, 10'd838, 10'd896,
        10'd736, 10'd779, 10'd393, 10'd424, 10'd79,  10'd196, 10'd136, 10'd321
    };

    typedef struct packed {
        logic [CFG_W-1:0] stuck_low;
        logic [CFG_W-1:0] stuck_high;
        logic [CFG_W-1:0] span_min;
        logic [CFG_W-1:0] span_max;
        logic [CFG_W-1:0] hysteresis;
    } wvsd_cfg_t;

    localparam wvsd_cfg_t CFG_RESET = '{
        stuck_low:  10'd3,
        stuck_high: 10'd1015,
        span_min:   10'd70,
        span_max:   10'd970,
        hysteresis: 10'd0
    };

    // reading as it travels down the match chain
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [SECTOR_W-1:0] best_idx;
        logic [SAMPLE_W-1:0] best_dist;
        logic [SAMPLE_W-1:0] mean;
        logic                fault;
    } wvsd_cell_t;

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // sector * 360 / 16 = sector * 45 / 2
    function automatic logic [DEG_W-1:0] sector_degrees(input logic [SECTOR_W-1:0] s);
        logic [SAMPLE_W-1:0] prod;
        prod = SAMPLE_W'(s) * SAMPLE_W'(45);
        return DEG_W'(prod >> 1);
    endfunction

endpackage
`default_nettype wire

>>> src/wvsd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsd_in_if
// Sample channel: valid/ready handshake carrying one raw ADC conversion.
// ----------------------------------------------------------------------------
interface wvsd_in_if
    import wvsd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

>>> src/wvsd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsd_out_if
// Reading channel: valid/ready handshake carrying one decoded reading.
// ----------------------------------------------------------------------------
interface wvsd_out_if
    import wvsd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SECTOR_W-1:0] sector;
    logic [DEG_W-1:0]    degrees;
    logic [SAMPLE_W-1:0] mean_sample;
    logic                fault;

    modport source (output valid, output sector, output degrees, output mean_sample,
                    output fault, input ready);
    modport sink   (input valid, input sector, input degrees, input mean_sample,
                    input fault, output ready);
endinterface
`default_nettype wire

>>> src/wind_vane_sector_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wind_vane_sector_decoder_core
// Averages raw vane ADC samples and decodes each reading into a held
// direction sector with fault detection and hysteresis.
//
// samples  : valid/ready sink, one 10-bit ADC conversion per transfer.
// readings : valid/ready source, one reading per SAMPLES_PER_READING samples
//            (sector, degrees, rounded mean, fault flag).
// cfg_*    : register write port, index 0..4 = stuck low, stuck high,
//            span min, span max, hysteresis; other indexes are dropped.
// Throughput: one sample transfer per cycle, sustained unless a stalled readings channel fills the pipeline.
// Pipeline: after the transfer of its last sample a reading passes the mean
// multiply, limit/clamp, 16 match cells and the output register.
// Reset clears the accumulator, the held sector (sector 0), the pipeline and
// restores the default register values.
// When readings is stalled each stage still fills any free slot; once every
// stage holds a reading, samples ready drops on the last sample of a group,
// other samples keep being accumulated.
// ----------------------------------------------------------------------------
module wind_vane_sector_decoder_core
    import wvsd_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    wvsd_in_if.sink                   samples,
    wvsd_out_if.source                readings,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    wvsd_cfg_t  cfg_reg, cfg_next;

    logic       chain_valid [SECTOR_COUNT+1];
    logic       chain_ready [SECTOR_COUNT+1];
    wvsd_cell_t chain_data  [SECTOR_COUNT+1];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_STUCK_LOW:  cfg_next.stuck_low  = cfg_wdata;
                REG_STUCK_HIGH: cfg_next.stuck_high = cfg_wdata;
                REG_SPAN_MIN:   cfg_next.span_min   = cfg_wdata;
                REG_SPAN_MAX:   cfg_next.span_max   = cfg_wdata;
                REG_HYSTERESIS: cfg_next.hysteresis = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wvsd_front #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .cfg        (cfg_reg),
        .down_valid (chain_valid[0]),
        .down_ready (chain_ready[0]),
        .down_data  (chain_data[0])
    );

    for (genvar g = 0; g < SECTOR_COUNT; g++)
    begin : g_cell
        wvsd_match_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .word       (LADDER[g]),
            .index      (SECTOR_W'(g)),
            .up_valid   (chain_valid[g]),
            .up_ready   (chain_ready[g]),
            .up_data    (chain_data[g]),
            .down_valid (chain_valid[g+1]),
            .down_ready (chain_ready[g+1]),
            .down_data  (chain_data[g+1])
        );
    end

    wvsd_hold u_hold (
        .clk        (clk),
        .rst_n      (rst_n),
        .hysteresis (cfg_reg.hysteresis),
        .up_valid   (chain_valid[SECTOR_COUNT]),
        .up_ready   (chain_ready[SECTOR_COUNT]),
        .up_data    (chain_data[SECTOR_COUNT]),
        .readings   (readings)
    );

endmodule
`default_nettype wire

>>> src/wvsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsd_front
// Sample accumulator, rounded mean by reciprocal multiply, then stuck-limit
// check and span clamp. Hands one reading to the match chain.
// ----------------------------------------------------------------------------
module wvsd_front
    import wvsd_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 7
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    wvsd_in_if.sink         samples,
    input  wire wvsd_cfg_t  cfg,
    output logic            down_valid,
    input  wire logic       down_ready,
    output wvsd_cell_t      down_data
);

    localparam int RECIP_SHIFT = 18;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + SAMPLES_PER_READING - 1)
                                 / SAMPLES_PER_READING;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RND_W       = SUM_W + 1;
    localparam int PROD_W      = RND_W + RECIP_W;
    localparam int HALF        = SAMPLES_PER_READING / 2;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic                c_valid_reg, c_valid_next;
    wvsd_cell_t          c_data_reg, c_data_next;

    logic                last;
    logic                accept;
    logic                m_load;
    logic                c_load;
    logic [SUM_W-1:0]    sum_total;
    logic [RND_W-1:0]    rounded;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] clamp_lo;

    assign last      = (count_reg == CNT_W'(SAMPLES_PER_READING - 1));
    assign c_load    = !c_valid_reg || down_ready;
    assign m_load    = !m_valid_reg || c_load;
    assign samples.ready = !last || m_load;
    assign accept    = samples.valid && samples.ready;
    assign sum_total = sum_reg + SUM_W'(samples.sample);
    assign rounded   = RND_W'(sum_total) + RND_W'(HALF);
    assign prod      = PROD_W'(rounded) * PROD_W'(RECIP);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_total;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        mean_next    = mean_reg;
        if (m_load)
        begin
            m_valid_next = accept && last;
            mean_next    = prod[RECIP_SHIFT +: SAMPLE_W];
        end
    end

    always_comb
    begin
        c_valid_next = c_valid_reg;
        c_data_next  = c_data_reg;
        clamp_lo     = (mean_reg < cfg.span_min) ? cfg.span_min : mean_reg;
        if (c_load)
        begin
            c_valid_next          = m_valid_reg;
            c_data_next.mean      = mean_reg;
            c_data_next.fault     = (mean_reg >= cfg.stuck_high) ||
                                    (mean_reg <= cfg.stuck_low);
            c_data_next.value     = (clamp_lo > cfg.span_max) ? cfg.span_max : clamp_lo;
            c_data_next.best_idx  = '0;
            c_data_next.best_dist = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg   <= mean_next;
        c_data_reg <= c_data_next;
    end

    assign down_valid = c_valid_reg;
    assign down_data  = c_data_reg;

endmodule
`default_nettype wire

>>> src/wvsd_match_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsd_match_cell
// One link of the nearest-match chain: compares the reading against its own
// ladder word and passes the running best index and distance downstream.
// ----------------------------------------------------------------------------
module wvsd_match_cell
    import wvsd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SAMPLE_W-1:0] word,
    input  wire logic [SECTOR_W-1:0] index,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire wvsd_cell_t          up_data,
    output logic                     down_valid,
    input  wire logic                down_ready,
    output wvsd_cell_t               down_data
);

    logic                valid_reg, valid_next;
    wvsd_cell_t          data_reg, data_next;
    logic                load;
    logic [SAMPLE_W-1:0] word_gap;

    assign load     = !valid_reg || down_ready;
    assign up_ready = load;
    assign word_gap = abs_diff(up_data.value, word);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = up_valid;
            data_next  = up_data;
            // strict compare keeps the lowest index on ties
            if (word_gap < up_data.best_dist)
            begin
                data_next.best_idx  = index;
                data_next.best_dist = word_gap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule
`default_nettype wire

>>> src/wvsd_hold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsd_hold
// Hysteresis decision against the held sector and the reading output
// register.
// ----------------------------------------------------------------------------
module wvsd_hold
    import wvsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CFG_W-1:0] hysteresis,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire wvsd_cell_t       up_data,
    wvsd_out_if.source            readings
);

    logic                held_reg_valid_dummy_unused;
    logic [SECTOR_W-1:0] held_reg, held_next;
    logic                out_valid_reg, out_valid_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [DEG_W-1:0]    degrees_reg, degrees_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic                fault_reg, fault_next;

    logic                load;
    logic                take;
    logic [SAMPLE_W-1:0] held_dist;
    logic [CFG_W:0]      cand_cost;
    logic [SECTOR_W-1:0] new_sector;

    assign held_reg_valid_dummy_unused = 1'b0;
    assign load      = !out_valid_reg || readings.ready;
    assign up_ready  = load;
    assign held_dist = abs_diff(up_data.value, LADDER[held_reg]);
    assign cand_cost = (CFG_W + 1)'(up_data.best_dist) + (CFG_W + 1)'(hysteresis);
    assign take      = !up_data.fault && (cand_cost < (CFG_W + 1)'(held_dist));
    assign new_sector = take ? up_data.best_idx : held_reg;

    always_comb
    begin
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        sector_next    = sector_reg;
        degrees_next   = degrees_reg;
        mean_next      = mean_reg;
        fault_next     = fault_reg;
        if (load)
        begin
            out_valid_next = up_valid;
            if (up_valid)
            begin
                held_next    = new_sector;
                sector_next  = new_sector;
                degrees_next = sector_degrees(new_sector);
                mean_next    = up_data.mean;
                fault_next   = up_data.fault;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg  <= sector_next;
        degrees_reg <= degrees_next;
        mean_reg    <= mean_next;
        fault_reg   <= fault_next;
    end

    assign readings.valid       = out_valid_reg;
    assign readings.sector      = sector_reg;
    assign readings.degrees     = degrees_reg;
    assign readings.mean_sample = mean_reg;
    assign readings.fault       = fault_reg | held_reg_valid_dummy_unused;

    // fault readings never move the held sector
    a_fault_holds: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && load && up_data.fault |=> held_reg == $past(held_reg))
        else $error("held sector moved on a fault reading");

    // held sector only changes when a reading is taken in
    a_held_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !(up_valid && load) |=> $stable(held_reg))
        else $error("held sector changed without a reading");

    // reported sector is always the held one
    a_sector_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> sector_reg == held_reg)
        else $error("reported sector differs from held sector");

    a_degrees: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> degrees_reg == sector_degrees(sector_reg))
        else $error("degrees do not match sector");

endmodule
`default_nettype wire

>>> verif/tb_wind_vane_sector_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wind_vane_sector_decoder_core
// Self-checking bench for the wind vane sector decoder. Groups of ADC samples
// go in over the sample channel and an in-bench decoder predicts each
// reading. Every reading transfer is checked against the oldest prediction.
// Test phases cover the field extremes, ignored register indexes, a long
// output hold that fills the pipeline, and a sweep of register settings.
// Settings in the sweep rotate through four mixes of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_wind_vane_sector_decoder_core;
    import wvsd_pkg::*;

    localparam int GROUP_SIZE       = 7;
    localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
    localparam int READING_LATENCY  = 19;
    localparam int SETTLE_CYCLES    = READING_LATENCY + 10;
    localparam int QUIET_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 700;
    localparam int FILL_GROUPS      = 36;
    localparam int REG_COUNT        = 5;
    localparam int INDEX_LIMIT      = 1 << CFG_IDX_W;
    localparam int SWEEP_PHASES     = 8;
    localparam int GROUPS_PER_PHASE = 13;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [DEG_W-1:0]    degrees;
        logic [SAMPLE_W-1:0] mean_sample;
        logic                fault;
    } reading_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    wvsd_in_if  samples_if ();
    wvsd_out_if readings_if ();

    wind_vane_sector_decoder_core #(
        .SAMPLES_PER_READING(GROUP_SIZE)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_if),
        .readings (readings_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    reading_t            pending_readings[$];
    wvsd_cfg_t           cur_cfg        = CFG_RESET;
    logic [SUM_W-1:0]    acc_sum        = '0;
    int                  acc_count      = 0;
    logic [SECTOR_W-1:0] held_sector    = '0;
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;
    int                  tx_gap_pct     = 0;
    int                  rx_stall_pct   = 0;
    int                  hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int ladder_gap(input int v, input int idx);
        int w;
        w = LADDER[idx];
        return (v > w) ? (v - w) : (w - v);
    endfunction

    task automatic decode_reading(input logic [SAMPLE_W-1:0] s);
        reading_t r;
        int       mean;
        int       v;
        int       cand;
        int       d;
        int       best_d;
        acc_sum = acc_sum + SUM_W'(s);
        acc_count++;
        if (acc_count == GROUP_SIZE)
        begin
            mean      = (int'(acc_sum) + GROUP_SIZE / 2) / GROUP_SIZE;
            acc_sum   = '0;
            acc_count = 0;
            r.fault   = (mean >= int'(cur_cfg.stuck_high)) || (mean <= int'(cur_cfg.stuck_low));
            if (!r.fault)
            begin
                v = mean;
                if (v < int'(cur_cfg.span_min))
                    v = cur_cfg.span_min;
                if (v > int'(cur_cfg.span_max))
                    v = cur_cfg.span_max;
                cand   = 0;
                best_d = ladder_gap(v, 0);
                for (int i = 1; i < SECTOR_COUNT; i++)
                begin
                    d = ladder_gap(v, i);
                    if (d < best_d)
                    begin
                        best_d = d;
                        cand   = i;
                    end
                end
                if (best_d + int'(cur_cfg.hysteresis) < ladder_gap(v, held_sector))
                    held_sector = SECTOR_W'(cand);
            end
            r.sector      = held_sector;
            r.degrees     = DEG_W'((int'(held_sector) * 360) / SECTOR_COUNT);
            r.mean_sample = SAMPLE_W'(mean);
            pending_readings.push_back(r);
        end
    endtask

    // receiver: random stalls, or a counted hold-off
    initial
    begin
        readings_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                readings_if.ready <= 1'b0;
            end
            else
                readings_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // reading checker, sampled mid-cycle ahead of the transfer edge
    initial
    begin
        reading_t want;
        forever
        begin
            @(negedge clk);
            if (readings_if.valid === 1'b1 && readings_if.ready === 1'b1)
            begin
                if (pending_readings.size() == 0)
                begin
                    $error("unexpected reading: sector %0d mean_sample %0d fault %0d",
                           readings_if.sector, readings_if.mean_sample, readings_if.fault);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (readings_if.sector !== want.sector)
                    begin
                        $error("sector mismatch: expected %0d, actual %0d",
                               want.sector, readings_if.sector);
                        mismatch_count++;
                    end
                    if (readings_if.degrees !== want.degrees)
                    begin
                        $error("degrees mismatch: expected %0d, actual %0d",
                               want.degrees, readings_if.degrees);
                        mismatch_count++;
                    end
                    if (readings_if.mean_sample !== want.mean_sample)
                    begin
                        $error("mean_sample mismatch: expected %0d, actual %0d",
                               want.mean_sample, readings_if.mean_sample);
                        mismatch_count++;
                    end
                    if (readings_if.fault !== want.fault)
                    begin
                        $error("fault mismatch: expected %0d, actual %0d",
                               want.fault, readings_if.fault);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((samples_if.valid === 1'b1 && samples_if.ready === 1'b1) ||
                (readings_if.valid === 1'b1 && readings_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        do
            @(negedge clk);
        while (samples_if.ready !== 1'b1);
        decode_reading(s);
        @(posedge clk);
    endtask

    task automatic send_group();
        int kind;
        int centre;
        int v;
        kind   = $urandom_range(0, 9);
        centre = int'(LADDER[$urandom_range(0, SECTOR_COUNT - 1)])
                 + int'($urandom_range(0, 80)) - 40;
        for (int k = 0; k < GROUP_SIZE; k++)
        begin
            case (kind)
                0, 1:    v = $urandom_range(0, SAMPLE_MAX);
                2:       v = $urandom_range(0, 8);
                3:       v = $urandom_range(SAMPLE_MAX - 11, SAMPLE_MAX);
                default: v = centre + int'($urandom_range(0, 6)) - 3;
            endcase
            if (v < 0)
                v = 0;
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            send_sample(SAMPLE_W'(v));
        end
    endtask

    task automatic wait_drained();
        samples_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input wvsd_cfg_t c);
        wait_drained();
        cfg_put(REG_STUCK_LOW, c.stuck_low);
        cfg_put(REG_STUCK_HIGH, c.stuck_high);
        cfg_put(REG_SPAN_MIN, c.span_min);
        cfg_put(REG_SPAN_MAX, c.span_max);
        cfg_put(REG_HYSTERESIS, c.hysteresis);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic test_directed_extremes();
        int tie_value;
        tie_value = (int'(LADDER[3]) + int'(LADDER[4])) / 2;
        repeat (GROUP_SIZE) send_sample('0);
        repeat (GROUP_SIZE) send_sample(SAMPLE_W'(SAMPLE_MAX));
        // equal distance to two ladder words
        repeat (GROUP_SIZE) send_sample(SAMPLE_W'(tie_value));
        for (int k = 0; k < GROUP_SIZE; k++)
            send_sample((k % 2 == 0) ? 10'h155 : 10'h2AA);
    endtask

    task automatic test_ignored_indexes();
        wait_drained();
        for (int idx = REG_COUNT; idx < INDEX_LIMIT; idx++)
            cfg_put(CFG_IDX_W'(idx), CFG_W'($urandom_range(0, SAMPLE_MAX)));
        cfg_we <= 1'b0;
        repeat (3) send_group();
    endtask

    task automatic test_backpressure_fill();
        wait_drained();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_left    = HOLD_CYCLES;
        repeat (FILL_GROUPS) send_group();
        wait_drained();
    endtask

    task automatic test_config_sweep();
        wvsd_cfg_t c;
        for (int phase = 0; phase < SWEEP_PHASES; phase++)
        begin
            c = CFG_RESET;
            case (phase)
                0:
                begin
                    c.hysteresis = $urandom_range(1, 40);
                end
                1:
                begin
                    c.stuck_low  = '0;
                    c.stuck_high = '1;
                    c.span_min   = '0;
                    c.span_max   = '1;
                    c.hysteresis = '0;
                end
                2:
                begin
                    // crossed clamp bounds
                    c.span_min = $urandom_range(512, SAMPLE_MAX);
                    c.span_max = $urandom_range(0, 511);
                end
                3:
                begin
                    c.hysteresis = '1;
                end
                4:
                begin
                    c.stuck_low  = $urandom_range(0, SAMPLE_MAX);
                    c.stuck_high = $urandom_range(0, SAMPLE_MAX);
                    c.span_min   = $urandom_range(0, SAMPLE_MAX);
                    c.span_max   = $urandom_range(0, SAMPLE_MAX);
                    c.hysteresis = $urandom_range(0, SAMPLE_MAX);
                end
                5:
                begin
                    c.stuck_low  = '1;
                    c.stuck_high = '0;
                end
                6:
                begin
                    c.span_min = $urandom_range(0, SAMPLE_MAX);
                    c.span_max = c.span_min;
                end
                default:
                begin
                    c.stuck_low  = $urandom_range(0, 100);
                    c.stuck_high = $urandom_range(900, SAMPLE_MAX);
                    c.span_min   = $urandom_range(0, 300);
                    c.span_max   = $urandom_range(700, SAMPLE_MAX);
                    c.hysteresis = $urandom_range(0, 60);
                end
            endcase
            apply_config(c);
            case (phase % 4)
                0:
                begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_gap_pct   = 57;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 57;
                end
                default:
                begin
                    tx_gap_pct   = 20;
                    rx_stall_pct = 20;
                end
            endcase
            repeat (GROUPS_PER_PHASE) send_group();
            // may leave a partial group in the accumulator
            repeat ($urandom_range(0, GROUP_SIZE - 1))
                send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_STUCK_LOW;
        cfg_wdata         <= '0;
        samples_if.valid  <= 1'b0;
        samples_if.sample <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_ignored_indexes();
        test_backpressure_fill();
        test_config_sweep();
        wait_drained();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
src/wvsd_pkg.sv
src/wvsd_in_if.sv
src/wvsd_out_if.sv
src/wvsd_front.sv
src/wvsd_match_cell.sv
src/wvsd_hold.sv
src/wind_vane_sector_decoder_core.sv
verif/tb_wind_vane_sector_decoder_core.sv
